// ----- hw/rtl/ldfl_pkg.sv -----
// Package for the line deframer with length limit: shared types and constants.
// Result word layout, status codes, character codes and output queue depth.
// No dependencies.
`timescale 1ns / 1ps

package ldfl_pkg;

  // default counter width and reset value of the line limit register
  localparam int unsigned LengthBitsDefault = 19;
  localparam int unsigned MaxLineBytesReset = 262144;

  // line terminator characters
  localparam logic [7:0] CharLf = 8'h0A;
  localparam logic [7:0] CharCr = 8'h0D;

  // result queue depth, power of two, at least two
  localparam int unsigned OutDepth = 4;

  // status codes carried with each result word
  typedef enum logic [2:0] {
    StByte         = 3'd0,
    StDone         = 3'd1,
    StEmpty        = 3'd2,
    StTooLong      = 3'd3,
    StUnterminated = 3'd4,
    StEnd          = 3'd5
  } status_e;

  // one result word
  typedef struct packed {
    logic [7:0] out_byte;
    status_e    status;
    logic       last;
  } result_t;

  // results produced by one input word, handed to the queue
  typedef struct packed {
    logic [1:0] cnt;
    result_t    r0;
    result_t    r1;
  } push_t;

endpackage

// ----- hw/rtl/line_deframer_length_limit_unit.sv -----
// Line deframer with length limit, top level.
// Channels in: one byte or end-of-stream word per handshake (valid/stall).
// Channel out: one result word per handshake: byte, line status, last flag.
// Single config register: the line length limit, written by cfg_we_i.
// Throughput: one input word per cycle while the result queue has room
// for two results; a word that makes two results (end of stream while
// dropping) puts two result words into the queue. A taken word is held
// in the input register, then written into the result queue, from which
// it is shown on the output.
// A word with no result (swallowed LF, dropped byte) just updates state.
// When the receiver stalls, results wait in a four-word queue; input is
// stalled once fewer than two queue slots are free, so bytes keep flowing
// while one result waits.
// Reset clears line state, empties the queue and sets the limit to 262144
// (masked to LENGTH_BITS bits). Write the limit only while the block is idle.
// Depends on ldfl_pkg, ldfl_core and ldfl_out_fifo.
`timescale 1ns / 1ps

module line_deframer_length_limit_unit import ldfl_pkg::*; #(
  parameter int unsigned LENGTH_BITS = LengthBitsDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [7:0]             data_byte_i,
  input  logic                   end_of_input_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [7:0]             out_byte_o,
  output logic [2:0]             status_o,
  output logic                   last_o,
  input  logic                   cfg_we_i,
  input  logic [LENGTH_BITS-1:0] cfg_wdata_i
);

  push_t   push;
  logic    room;
  result_t head;

  // line state and decode
  ldfl_core #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .data_byte_i   (data_byte_i),
    .end_of_input_i(end_of_input_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .room_i        (room),
    .push_o        (push)
  );

  // result queue
  ldfl_out_fifo u_out_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .room_o     (room),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .head_o     (head)
  );

  assign out_byte_o = head.out_byte;
  assign status_o   = head.status;
  assign last_o     = head.last;

endmodule

// ----- hw/rtl/ldfl_core.sv -----
// Line deframer core: input register, line state and result decode.
// Depends on ldfl_pkg; feeds ldfl_out_fifo with up to two results per word.
`timescale 1ns / 1ps

module ldfl_core import ldfl_pkg::*; #(
  parameter int unsigned LENGTH_BITS = LengthBitsDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [7:0]             data_byte_i,
  input  logic                   end_of_input_i,
  input  logic                   cfg_we_i,
  input  logic [LENGTH_BITS-1:0] cfg_wdata_i,
  input  logic                   room_i,
  output push_t                  push_o
);

  localparam logic [LENGTH_BITS-1:0] MaxReset = LENGTH_BITS'(MaxLineBytesReset);

  logic                   item_vld_q, item_vld_d;
  logic [7:0]             item_byte_q;
  logic                   item_eoi_q;
  logic [LENGTH_BITS-1:0] max_q;
  logic [LENGTH_BITS-1:0] len_q, len_d;
  logic                   drop_q, drop_d;
  logic                   cr_q, cr_d;
  logic                   consume;
  logic                   load;
  logic                   is_term;
  push_t                  push;

  // item is processed once the queue has room for two results
  assign consume    = item_vld_q && room_i;
  assign in_stall_o = item_vld_q && !room_i;
  assign load       = in_valid_i && !in_stall_o;
  assign item_vld_d = load ? 1'b1 : (consume ? 1'b0 : item_vld_q);

  // input register, payload not reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
    end else begin
      item_vld_q <= item_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_byte_q <= data_byte_i;
      item_eoi_q  <= end_of_input_i;
    end
  end

  // line limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= MaxReset;
    end else if (cfg_we_i) begin
      max_q <= cfg_wdata_i;
    end
  end

  assign is_term = (item_byte_q == CharLf) || (item_byte_q == CharCr);

  // result decode and next line state
  always_comb begin
    len_d     = len_q;
    drop_d    = drop_q;
    cr_d      = cr_q;
    push      = '0;
    push.r0.status = StByte;
    push.r1.status = StEnd;
    if (item_eoi_q) begin
      // end of stream closes everything
      len_d  = '0;
      drop_d = 1'b0;
      cr_d   = 1'b0;
      if (drop_q) begin
        push.cnt       = 2'd2;
        push.r0.status = StTooLong;
        push.r1.status = StEnd;
        push.r1.last   = 1'b1;
      end else begin
        push.cnt       = 2'd1;
        push.r0.status = (len_q != '0) ? StUnterminated : StEnd;
        push.r0.last   = 1'b1;
      end
    end else if (cr_q && (item_byte_q == CharLf)) begin
      // LF of a CRLF pair
      cr_d = 1'b0;
    end else if (is_term) begin
      push.cnt     = 2'd1;
      push.r0.last = 1'b1;
      if (drop_q) begin
        push.r0.status = StTooLong;
      end else if (len_q == '0) begin
        push.r0.status = StEmpty;
      end else begin
        push.r0.status = StDone;
      end
      drop_d = 1'b0;
      len_d  = '0;
      cr_d   = (item_byte_q == CharCr);
    end else begin
      cr_d = 1'b0;
      if (drop_q) begin
        // discard until terminator
      end else if (len_q >= max_q) begin
        len_d  = max_q;
        drop_d = 1'b1;
      end else begin
        len_d            = len_q + LENGTH_BITS'(1);
        push.cnt         = 2'd1;
        push.r0.out_byte = item_byte_q;
        push.r0.status   = StByte;
        push.r0.last     = 1'b1;
      end
    end
    if (!consume) begin
      push.cnt = 2'd0;
    end
  end

  // line state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= '0;
      drop_q <= 1'b0;
      cr_q   <= 1'b0;
    end else if (consume) begin
      len_q  <= len_d;
      drop_q <= drop_d;
      cr_q   <= cr_d;
    end
  end

  assign push_o = push;

  // end of stream always returns the line state to its idle values
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    consume && item_eoi_q |=> (len_q == '0) && !drop_q && !cr_q)
    else $error("line state not cleared after end of stream");

  // two results only for end of stream while dropping
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.cnt == 2'd2 |-> item_eoi_q && drop_q)
    else $error("double result outside end of stream while dropping");

  // nothing is pushed without a processed word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.cnt != 2'd0 |-> consume)
    else $error("result pushed without a processed word");

endmodule

// ----- hw/rtl/ldfl_out_fifo.sv -----
// Result queue of the line deframer: takes up to two words per cycle,
// presents one per cycle at the output unless stalled. Depends on ldfl_pkg.
`timescale 1ns / 1ps

module ldfl_out_fifo import ldfl_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  push_t   push_i,
  output logic    room_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output result_t head_o
);

  localparam int unsigned AddrW = $clog2(OutDepth);
  localparam int unsigned CntW  = $clog2(OutDepth + 1);

  result_t              mem_q [OutDepth];
  logic [AddrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [AddrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]      count_q, count_d;
  logic                 pop;

  // room for two words, counted before this cycle's pop
  assign room_o      = count_q <= CntW'(OutDepth - 2);
  assign out_valid_o = count_q != '0;
  assign pop         = out_valid_o && !out_stall_i;
  assign head_o      = mem_q[rd_ptr_q];

  assign wr_ptr_d = wr_ptr_q + AddrW'(push_i.cnt);
  assign rd_ptr_d = rd_ptr_q + AddrW'(pop);
  assign count_d  = count_q + CntW'(push_i.cnt) - CntW'(pop);

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage writes
  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.r0;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wr_ptr_q + AddrW'(1)] <= push_i.r1;
    end
  end

  // never pushed beyond capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.cnt != 2'd0 |-> count_q <= CntW'(OutDepth - 2))
    else $error("result queue overflow");

  // fill count tracks the pointer distance
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != '0 && count_q != CntW'(OutDepth)) |->
      (AddrW'(wr_ptr_q - rd_ptr_q) == AddrW'(count_q)))
    else $error("result queue count and pointers disagree");

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for line_deframer_length_limit_unit.
// Directed table then random line traffic, checked word by word against a line predictor.
// Depends on ldfl_pkg and the line deframer RTL.
`timescale 1ns / 1ps

module testbench;
  import ldfl_pkg::*;

  localparam int unsigned LenBits       = LengthBitsDefault;
  localparam int          DrainCycles   = 4;
  localparam int          ChokeCycles   = 200;
  localparam int          WatchdogLimit = 2000;
  localparam int          PhaseWords    = 88;
  localparam int          NumPhases     = 8;

  // one row of stimulus: a limit write or an input word, with optional typed-in results
  typedef struct packed {
    logic               is_cfg;
    logic [LenBits-1:0] limit;
    logic [7:0]         data;
    logic               eoi;
    logic               pinned;
    logic [1:0]         n;
    status_e            s0;
    status_e            s1;
  } stim_row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [7:0]         data_byte_i;
  logic               end_of_input_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [7:0]         out_byte_o;
  logic [2:0]         status_o;
  logic               last_o;
  logic               cfg_we_i;
  logic [LenBits-1:0] cfg_wdata_i;

  // predictor state
  logic [LenBits-1:0] line_len   = '0;
  logic               dropping   = 1'b0;
  logic               after_cr   = 1'b0;
  logic [LenBits-1:0] line_limit = LenBits'(MaxLineBytesReset);

  result_t   pending_results [$];
  stim_row_t directed_rows [$];
  stim_row_t cur_row;
  int        error_count = 0;
  int        idle_cycles = 0;
  int        words_sent  = 0;
  int        rush_left   = 0;
  logic      tx_calm     = 1'b0;
  logic      choke_req   = 1'b0;

  line_deframer_length_limit_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .data_byte_i    (data_byte_i),
    .end_of_input_i (end_of_input_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_byte_o     (out_byte_o),
    .status_o       (status_o),
    .last_o         (last_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic flag_error(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) flag_error($sformatf("%s got %0d, expected %0d", name, got, want));
  endtask

  // line predictor: advances the line state by one word, returns the number of results
  function automatic int deframe_word(input logic [7:0] b, input logic eoi,
                                      output result_t r0, output result_t r1);
    int n;
    n = 0;
    r0 = '0;
    r1 = '0;
    if (eoi) begin
      if (dropping) begin
        r0.status = StTooLong;
        r1.status = StEnd;
        n = 2;
      end else if (line_len != '0) begin
        r0.status = StUnterminated;
        n = 1;
      end else begin
        r0.status = StEnd;
        n = 1;
      end
      line_len = '0;
      dropping = 1'b0;
      after_cr = 1'b0;
    end else if (after_cr && b == CharLf) begin
      // lf of a crlf pair
      after_cr = 1'b0;
    end else if (b == CharLf || b == CharCr) begin
      if (dropping) r0.status = StTooLong;
      else if (line_len == '0) r0.status = StEmpty;
      else r0.status = StDone;
      n = 1;
      dropping = 1'b0;
      line_len = '0;
      after_cr = (b == CharCr);
    end else begin
      after_cr = 1'b0;
      if (!dropping) begin
        if (line_len >= line_limit) begin
          // overflowing byte starts the drop
          line_len = line_limit;
          dropping = 1'b1;
        end else begin
          line_len = line_len + LenBits'(1);
          r0.out_byte = b;
          r0.status = StByte;
          n = 1;
        end
      end
    end
    if (n == 1) r0.last = 1'b1;
    if (n == 2) r1.last = 1'b1;
    return n;
  endfunction

  function automatic stim_row_t plain_word(input logic [7:0] b, input logic eoi);
    stim_row_t row;
    row = '0;
    row.data = b;
    row.eoi = eoi;
    return row;
  endfunction

  function automatic stim_row_t pinned_word(input logic [7:0] b, input logic eoi,
                                            input logic [1:0] n, input status_e s0,
                                            input status_e s1);
    stim_row_t row;
    row = plain_word(b, eoi);
    row.pinned = 1'b1;
    row.n = n;
    row.s0 = s0;
    row.s1 = s1;
    return row;
  endfunction

  function automatic stim_row_t cfg_row(input logic [LenBits-1:0] v);
    stim_row_t row;
    row = '0;
    row.is_cfg = 1'b1;
    row.limit = v;
    return row;
  endfunction

  // append one row to the directed table
  task automatic add_row(input stim_row_t row);
    directed_rows.insert(directed_rows.size(), row);
  endtask

  function automatic logic [7:0] line_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == CharLf || c == CharCr);
    return c;
  endfunction

  // monitor: predict on input words, check output words, track limit writes
  always @(posedge clk_i) begin : monitor
    result_t r0, r1, got, want;
    int      n;
    logic    hit;
    hit = 1'b0;
    if (in_valid_i && !in_stall_o) begin
      n = deframe_word(data_byte_i, end_of_input_i, r0, r1);
      if (cur_row.pinned) begin
        n = cur_row.n;
        r0 = '0;
        r1 = '0;
        r0.status = cur_row.s0;
        r1.status = cur_row.s1;
        if (cur_row.s0 == StByte) r0.out_byte = data_byte_i;
        if (n == 1) r0.last = 1'b1;
        if (n == 2) r1.last = 1'b1;
      end
      if (n > 0) pending_results.insert(pending_results.size(), r0);
      if (n > 1) pending_results.insert(pending_results.size(), r1);
      hit = 1'b1;
    end
    if (out_valid_o && !out_stall_i) begin
      got.out_byte = out_byte_o;
      got.status = status_e'(status_o);
      got.last = last_o;
      if (pending_results.size() == 0) begin
        flag_error($sformatf("unexpected result word status %0d", status_o));
      end else begin
        want = pending_results.pop_front();
        check_field("out_byte", int'(got.out_byte), int'(want.out_byte));
        check_field("status", int'(got.status), int'(want.status));
        check_field("last", int'(got.last), int'(want.last));
      end
      hit = 1'b1;
    end
    if (cfg_we_i) line_limit = cfg_wdata_i;
    idle_cycles = hit ? 0 : idle_cycles + 1;
  end

  // watchdog on handshake inactivity
  initial begin
    while (idle_cycles < WatchdogLimit) @(posedge clk_i);
    $display("*** FAILED ***");
    $finish;
  end

  // receiver: random stall per word, calm stretches, one long hold-off on request
  initial begin : receiver
    int   hold;
    int   calm_left;
    logic calm;
    out_stall_i = 1'b0;
    calm_left = 0;
    calm = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (calm_left == 0) begin
        calm_left = $urandom_range(1, 30);
        calm = ($urandom_range(0, 3) == 0);
      end
      calm_left--;
      hold = calm ? 0 : $urandom_range(0, 17);
      if (choke_req) begin
        choke_req = 1'b0;
        hold = ChokeCycles;
      end
      if (hold != 0) begin
        out_stall_i = 1'b1;
        repeat (hold) @(negedge clk_i);
      end
      out_stall_i = 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      @(negedge clk_i);
    end
  end

  // sender: offers one word, returns at the falling edge after it is taken
  task automatic send_word(input stim_row_t row);
    int gap;
    gap = (rush_left > 0 || tx_calm) ? 0 : $urandom_range(0, 17);
    if (rush_left > 0) rush_left--;
    if (gap != 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    cur_row = row;
    data_byte_i = row.data;
    end_of_input_i = row.eoi;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    words_sent++;
  endtask

  // block idle: nothing pending and the pipeline flushed
  task automatic wait_idle();
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_limit(input logic [LenBits-1:0] v);
    in_valid_i = 1'b0;
    wait_idle();
    cfg_wdata_i = v;
    cfg_we_i = 1'b1;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // one random line: mostly well formed, some noise
  task automatic send_random_line(input logic [LenBits-1:0] lim);
    int span;
    int len;
    int pick;
    tx_calm = ($urandom_range(0, 3) == 0);
    if ($urandom_range(0, 9) < 8) begin
      span = (lim < 8) ? int'(lim) + 2 : 8;
      if ($urandom_range(0, 7) == 0) span = 24;
      len = $urandom_range(0, span);
      repeat (len) send_word(plain_word(line_char(), 1'b0));
      pick = $urandom_range(0, 7);
      if (pick <= 2) begin
        send_word(plain_word(CharLf, 1'b0));
      end else if (pick <= 4) begin
        send_word(plain_word(CharCr, 1'b0));
      end else if (pick <= 6) begin
        send_word(plain_word(CharCr, 1'b0));
        send_word(plain_word(CharLf, 1'b0));
      end else begin
        send_word(plain_word(8'($urandom_range(0, 255)), 1'b1));
      end
    end else begin
      repeat ($urandom_range(1, 4))
        send_word(plain_word(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0));
    end
  endtask

  // main sequence
  initial begin : stimulus
    logic [LenBits-1:0] lim;
    in_valid_i = 1'b0;
    data_byte_i = '0;
    end_of_input_i = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    cur_row = '0;
    rst_ni = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed table, reset limit first
    add_row(pinned_word(CharLf, 1'b1, 2'd1, StEnd, StByte));
    add_row(pinned_word(CharLf, 1'b0, 2'd1, StEmpty, StByte));
    add_row(pinned_word(CharCr, 1'b0, 2'd1, StEmpty, StByte));
    add_row(pinned_word(CharLf, 1'b0, 2'd0, StByte, StByte));
    add_row(pinned_word(CharLf, 1'b0, 2'd1, StEmpty, StByte));
    add_row(pinned_word(8'h00, 1'b0, 2'd1, StByte, StByte));
    add_row(pinned_word(8'hFF, 1'b0, 2'd1, StByte, StByte));
    add_row(pinned_word(CharCr, 1'b0, 2'd1, StDone, StByte));
    add_row(plain_word(8'h41, 1'b0));
    add_row(pinned_word(8'h00, 1'b1, 2'd1, StUnterminated, StByte));
    // limit of two: overflow, crlf after too long, line exactly at limit, end while dropping
    add_row(cfg_row(LenBits'(2)));
    add_row(plain_word(8'h61, 1'b0));
    add_row(plain_word(8'h62, 1'b0));
    add_row(pinned_word(8'h63, 1'b0, 2'd0, StByte, StByte));
    add_row(pinned_word(CharCr, 1'b0, 2'd1, StTooLong, StByte));
    add_row(pinned_word(CharLf, 1'b0, 2'd0, StByte, StByte));
    add_row(plain_word(8'h78, 1'b0));
    add_row(plain_word(8'h79, 1'b0));
    add_row(pinned_word(CharLf, 1'b0, 2'd1, StDone, StByte));
    add_row(plain_word(8'h70, 1'b0));
    add_row(plain_word(8'h71, 1'b0));
    add_row(pinned_word(8'h72, 1'b0, 2'd0, StByte, StByte));
    add_row(pinned_word(8'h00, 1'b1, 2'd2, StTooLong, StEnd));
    // limit of zero: every line byte dropped
    add_row(cfg_row('0));
    add_row(pinned_word(8'h7A, 1'b0, 2'd0, StByte, StByte));
    add_row(pinned_word(CharLf, 1'b0, 2'd1, StTooLong, StByte));
    add_row(pinned_word(CharLf, 1'b0, 2'd1, StEmpty, StByte));
    add_row(pinned_word(8'h00, 1'b1, 2'd1, StEnd, StByte));

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) write_limit(directed_rows[i].limit);
      else send_word(directed_rows[i]);
    end

    // random phases over a spread of limits
    for (int phase = 0; phase < NumPhases; phase++) begin
      case (phase)
        0: lim = LenBits'(1);
        1: lim = LenBits'(3);
        2: lim = '0;
        3: lim = LenBits'(2);
        4: lim = LenBits'($urandom_range(1, 12));
        5: lim = LenBits'(MaxLineBytesReset);
        6: lim = '1;
        default: lim = LenBits'($urandom_range(4, 9));
      endcase
      write_limit(lim);
      if (phase == 1) begin
        // long receiver hold-off while the sender keeps pushing
        choke_req = 1'b1;
        rush_left = 60;
      end
      words_sent = 0;
      while (words_sent < PhaseWords) send_random_line(lim);
    end

    // drain and report
    in_valid_i = 1'b0;
    wait_idle();
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/ldfl_pkg.sv
hw/rtl/ldfl_core.sv
hw/rtl/ldfl_out_fifo.sv
hw/rtl/line_deframer_length_limit_unit.sv
dv/testbench.sv
